// ===== hw/rtl/nps_pkg.sv =====
// nps_pkg: widths, limits, register indexes and the shared root status type for the
// nearest pose search unit
// depends on nothing; used by every rtl file of the block
package nps_pkg;

    // coordinate and result widths
    localparam int POSE_W    = 24;
    localparam int DIFF_W    = POSE_W + 1;
    localparam int IDX_W     = 10;
    localparam int SQ_W      = 2 * POSE_W + 1;
    localparam int ROOT_W    = 25;
    localparam int PROD_W    = 2 * POSE_W;

    // trajectory length limit and pose counter width
    localparam int MAX_POSES = 1024;
    localparam int CNT_W     = $clog2(MAX_POSES + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_INDEX = 2'd2;

    // square root unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_root_stat;

endpackage

// ===== hw/rtl/nearest_pose_search_unit.sv =====
// nearest_pose_search_unit: top level, sequencer, search state and result register
// depends on nps_pkg, nps_square and nps_isqrt
//
//  channel   direction  handshake                     payload
//  pose      in         i_pose_valid / o_pose_ready   i_pose_x, i_pose_y, i_last_pose
//  result    out        o_res_valid / i_res_ready     o_found, o_nearest_index,
//                                                     o_nearest_distance
//  config    in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// a searched pose passes the SQX, SQY and CMP states before the next ready,
// as the one squaring unit forms dx squared and then dy squared before the
// add and compare; a skipped or ignored pose is taken in the idle state alone
// a last pose adds the START, ROOT and EMIT states: START starts the root, ROOT
// forms the 25 root bits until the done flag, and EMIT loads the result
// register, which waits there while the previous result is untaken
// reset is synchronous, active low, and clears the configuration registers and the search state
module nearest_pose_search_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_pose_valid,
    output logic                                o_pose_ready,
    input  logic signed [nps_pkg::POSE_W-1:0]   i_pose_x,
    input  logic signed [nps_pkg::POSE_W-1:0]   i_pose_y,
    input  logic                                i_last_pose,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_found,
    output logic [nps_pkg::IDX_W-1:0]           o_nearest_index,
    output logic [nps_pkg::ROOT_W-1:0]          o_nearest_distance
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQX   = 3'd1;
    localparam logic [2:0] ST_SQY   = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_ROOT  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // configuration registers
    logic signed [nps_pkg::POSE_W-1:0] r_ref_x;
    logic signed [nps_pkg::POSE_W-1:0] r_ref_y;
    logic [nps_pkg::IDX_W-1:0]         r_begin_index;

    // sequencer and trajectory state
    logic [2:0]                  r_state, n_state;
    logic [nps_pkg::CNT_W-1:0]   r_count;
    logic [nps_pkg::IDX_W-1:0]   r_best_index;
    logic [nps_pkg::SQ_W-1:0]    r_best_sq;
    logic                        r_have_best;

    // current pose
    logic signed [nps_pkg::DIFF_W-1:0] r_dx;
    logic signed [nps_pkg::DIFF_W-1:0] r_dy;
    logic [nps_pkg::IDX_W-1:0]         r_idx;
    logic                              r_last;
    logic [nps_pkg::PROD_W-1:0]        r_acc;

    // result register
    logic                         r_out_valid;
    logic                         r_found;
    logic [nps_pkg::IDX_W-1:0]    r_nidx;
    logic [nps_pkg::ROOT_W-1:0]   r_ndist;

    logic                               w_accept;
    logic                               w_in_range;
    logic                               w_search;
    logic [nps_pkg::DIFF_W-1:0]         w_mag;
    logic [nps_pkg::POSE_W-1:0]         w_sq_in;
    logic [nps_pkg::PROD_W-1:0]         w_prod;
    logic [nps_pkg::SQ_W-1:0]           w_sum;
    logic                               w_better;
    logic                               w_out_free;
    logic [nps_pkg::ROOT_W-1:0]         w_root;
    nps_pkg::t_root_stat                w_root_stat;

    assign o_pose_ready = (r_state == ST_IDLE);
    assign w_accept     = i_pose_valid && o_pose_ready;
    assign w_in_range   = (r_count < nps_pkg::CNT_W'(nps_pkg::MAX_POSES));
    assign w_search     = w_in_range
                       && (r_count >= nps_pkg::CNT_W'(r_begin_index));
    assign w_out_free   = !r_out_valid || i_res_ready;

    // magnitude of the difference being squared this cycle
    assign w_mag   = (r_state == ST_SQX) ? (r_dx[nps_pkg::DIFF_W-1] ? -r_dx : r_dx)
                                         : (r_dy[nps_pkg::DIFF_W-1] ? -r_dy : r_dy);
    assign w_sq_in = w_mag[nps_pkg::POSE_W-1:0];

    nps_square u_square (
        .i_clk (i_clk),
        .i_a   (w_sq_in),
        .o_p   (w_prod)
    );

    // squared distance and strict minimum test
    assign w_sum    = nps_pkg::SQ_W'(r_acc) + nps_pkg::SQ_W'(w_prod);
    assign w_better = !r_have_best || (w_sum < r_best_sq);

    nps_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_value (r_best_sq),
        .o_root  (w_root),
        .o_stat  (w_root_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_search) begin
                        n_state = ST_SQX;
                    end else if (i_last_pose) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = ST_CMP;
            ST_CMP:   n_state = r_last ? ST_START : ST_IDLE;
            ST_START: n_state = ST_ROOT;
            ST_ROOT: begin
                if (w_root_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x       <= '0;
            r_ref_y       <= '0;
            r_begin_index <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nps_pkg::CFG_REF_X:       r_ref_x <= i_cfg_data;
                nps_pkg::CFG_REF_Y:       r_ref_y <= i_cfg_data;
                nps_pkg::CFG_BEGIN_INDEX: r_begin_index <= i_cfg_data[nps_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and trajectory state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_best_index <= '0;
            r_best_sq    <= '0;
            r_have_best  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && w_in_range) begin
                r_count <= r_count + 1'b1;
            end
            if ((r_state == ST_CMP) && w_better) begin
                r_best_sq    <= w_sum;
                r_best_index <= r_idx;
                r_have_best  <= 1'b1;
            end
            if ((r_state == ST_EMIT) && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_count      <= '0;
                r_best_index <= '0;
                r_best_sq    <= '0;
                r_have_best  <= 1'b0;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pose capture and first square
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dx   <= nps_pkg::DIFF_W'(r_ref_x) - nps_pkg::DIFF_W'(i_pose_x);
            r_dy   <= nps_pkg::DIFF_W'(r_ref_y) - nps_pkg::DIFF_W'(i_pose_y);
            r_idx  <= r_count[nps_pkg::IDX_W-1:0];
            r_last <= i_last_pose;
        end
        if (r_state == ST_SQY) begin
            r_acc <= w_prod;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && w_out_free) begin
            r_found <= r_have_best;
            r_nidx  <= r_best_index;
            r_ndist <= w_root;
        end
    end

    assign o_res_valid        = r_out_valid;
    assign o_found            = r_found;
    assign o_nearest_index    = r_nidx;
    assign o_nearest_distance = r_ndist;

`ifndef ASSERT_OFF
    // no pose request is taken while the root is being formed
    a_ready_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pose_ready |-> !w_root_stat.busy)
        else $error("pose ready while square root busy");

    // an empty search reports zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_found) |-> (o_nearest_index == '0 && o_nearest_distance == '0))
        else $error("not found result carries nonzero fields");

    // the root done flag rises only in the root state, ahead of the result load
    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_stat.done |-> (r_state == ST_ROOT))
        else $error("square root done outside root state");

    // a new result is loaded only from the emit state
    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("result loaded outside emit state");
`endif

endmodule

// ===== hw/rtl/nps_square.sv =====
// nps_square: shared registered squaring unit, 24 x 24 bits
// depends on nps_pkg
module nps_square (
    input  logic                        i_clk,
    input  logic [nps_pkg::POSE_W-1:0]  i_a,
    output logic [nps_pkg::PROD_W-1:0]  o_p
);

    logic [nps_pkg::PROD_W-1:0] r_p;

    // one product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_p <= nps_pkg::PROD_W'(i_a) * nps_pkg::PROD_W'(i_a);
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/nps_isqrt.sv =====
// nps_isqrt: iterative floor square root, one root bit per cycle
// depends on nps_pkg
module nps_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nps_pkg::SQ_W-1:0]    i_value,
    output logic [nps_pkg::ROOT_W-1:0]  o_root,
    output nps_pkg::t_root_stat         o_stat
);

    localparam int VAL_W  = 2 * nps_pkg::ROOT_W;
    localparam int REM_W  = nps_pkg::ROOT_W + 2;
    localparam int WORK_W = REM_W + 2;
    localparam int STEP_W = $clog2(nps_pkg::ROOT_W);

    logic [VAL_W-1:0]           r_val;
    logic [REM_W-1:0]           r_rem;
    logic [nps_pkg::ROOT_W-1:0] r_root;
    logic [STEP_W-1:0]          r_step;
    logic                       r_busy;
    logic                       r_done;

    logic [WORK_W-1:0] w_cur;
    logic [WORK_W-1:0] w_trial;
    logic [WORK_W-1:0] w_diff;
    logic              w_ge;

    // bring down two bits and try the next root bit
    assign w_cur   = {r_rem, r_val[VAL_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_diff  = w_cur - w_trial;
    assign w_ge    = (w_cur >= w_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(nps_pkg::ROOT_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= VAL_W'(i_value);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[VAL_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];
            r_root <= {r_root[nps_pkg::ROOT_W-2:0], w_ge};
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== test/nps_result_checker.sv =====
`timescale 1ns / 100ps
// nps_result_checker: follows the register, pose and result ports of the nearest
// pose search unit, predicts each result and compares it field by field
// depends on nps_pkg
module nps_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_pose_valid,
    input  logic                              i_pose_ready,
    input  logic signed [nps_pkg::POSE_W-1:0] i_pose_x,
    input  logic signed [nps_pkg::POSE_W-1:0] i_pose_y,
    input  logic                              i_last_pose,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic                              i_found,
    input  logic [nps_pkg::IDX_W-1:0]         i_nearest_index,
    input  logic [nps_pkg::ROOT_W-1:0]        i_nearest_distance,
    output int                                o_err_count,
    output int                                o_pending,
    output int                                o_res_count
);

    typedef struct packed {
        logic                       found;
        logic [nps_pkg::IDX_W-1:0]  index;
        logic [nps_pkg::ROOT_W-1:0] distance;
    } t_nearest;

    // results still owed by the block, oldest first
    t_nearest nearest_q[$];

    // copy of the registers
    logic signed [nps_pkg::POSE_W-1:0] ref_x_q;
    logic signed [nps_pkg::POSE_W-1:0] ref_y_q;
    logic [nps_pkg::IDX_W-1:0]         begin_q;

    // copy of the trajectory state
    logic [nps_pkg::CNT_W-1:0] pose_slot;
    logic [nps_pkg::IDX_W-1:0] closest_index;
    logic [nps_pkg::SQ_W-1:0]  closest_sq;
    logic                      have_closest;

    int err_count;
    int res_count;

    // exact squared distance from the reference point
    function automatic logic [nps_pkg::SQ_W-1:0] square_distance(
        input logic signed [nps_pkg::POSE_W-1:0] rx,
        input logic signed [nps_pkg::POSE_W-1:0] ry,
        input logic signed [nps_pkg::POSE_W-1:0] px,
        input logic signed [nps_pkg::POSE_W-1:0] py
    );
        longint     dx;
        longint     dy;
        logic [63:0] sum;
        dx  = longint'(rx) - longint'(px);
        dy  = longint'(ry) - longint'(py);
        sum = dx * dx + dy * dy;
        return sum[nps_pkg::SQ_W-1:0];
    endfunction

    // integer floor root, one result bit at a time from the top
    function automatic logic [nps_pkg::ROOT_W-1:0] floor_root(
        input logic [nps_pkg::SQ_W-1:0] value
    );
        logic [nps_pkg::ROOT_W-1:0] root;
        logic [nps_pkg::ROOT_W-1:0] root_try;
        logic [63:0]                widened;
        logic [63:0]                square;
        logic [63:0]                target;
        root   = '0;
        target = 64'(value);
        for (int b = nps_pkg::ROOT_W - 1; b >= 0; b--) begin
            root_try    = root;
            root_try[b] = 1'b1;
            widened     = 64'(root_try);
            square      = widened * widened;
            if (square <= target) begin
                root = root_try;
            end
        end
        return root;
    endfunction

    task automatic clear_search();
        pose_slot     = '0;
        closest_index = '0;
        closest_sq    = '0;
        have_closest  = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_nearest                 want;
        t_nearest                 got;
        logic [nps_pkg::SQ_W-1:0] sq;
        if (!i_rst_n) begin
            ref_x_q   = '0;
            ref_y_q   = '0;
            begin_q   = '0;
            clear_search();
            nearest_q.delete();
            err_count = 0;
            res_count = 0;
        end else begin
            // pose request: search if in range, close trajectory on a last pose
            if (i_pose_valid && i_pose_ready) begin
                if (pose_slot < nps_pkg::CNT_W'(nps_pkg::MAX_POSES)) begin
                    if (pose_slot >= nps_pkg::CNT_W'(begin_q)) begin
                        sq = square_distance(ref_x_q, ref_y_q, i_pose_x, i_pose_y);
                        if (!have_closest || sq < closest_sq) begin
                            closest_sq    = sq;
                            closest_index = pose_slot[nps_pkg::IDX_W-1:0];
                            have_closest  = 1'b1;
                        end
                    end
                    pose_slot = pose_slot + 1'b1;
                end
                if (i_last_pose) begin
                    want.found    = have_closest;
                    want.index    = have_closest ? closest_index : '0;
                    want.distance = have_closest ? floor_root(closest_sq) : '0;
                    nearest_q     = {nearest_q, want};
                    clear_search();
                end
            end

            // register writes, unused index ignored
            if (i_cfg_we) begin
                case (i_cfg_index)
                    nps_pkg::CFG_REF_X:       ref_x_q = i_cfg_data;
                    nps_pkg::CFG_REF_Y:       ref_y_q = i_cfg_data;
                    nps_pkg::CFG_BEGIN_INDEX: begin_q = i_cfg_data[nps_pkg::IDX_W-1:0];
                    default: ;
                endcase
            end

            // result request against the oldest prediction
            if (i_res_valid && i_res_ready) begin
                got.found    = i_found;
                got.index    = i_nearest_index;
                got.distance = i_nearest_distance;
                res_count    = res_count + 1;
                if (nearest_q.size() == 0) begin
                    $display("%0t: result with none expected, found %0d index %0d distance %0d",
                             $time, got.found, got.index, got.distance);
                    err_count = err_count + 1;
                end else begin
                    want = nearest_q.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found mismatch, expected %0d, actual %0d",
                                 $time, want.found, got.found);
                        err_count = err_count + 1;
                    end
                    if (got.index !== want.index) begin
                        $display("%0t: nearest_index mismatch, expected %0d, actual %0d",
                                 $time, want.index, got.index);
                        err_count = err_count + 1;
                    end
                    if (got.distance !== want.distance) begin
                        $display("%0t: nearest_distance mismatch, expected %0d, actual %0d",
                                 $time, want.distance, got.distance);
                        err_count = err_count + 1;
                    end
                end
            end
        end
        o_err_count <= err_count;
        o_pending   <= nearest_q.size();
        o_res_count <= res_count;
    end

endmodule

// ===== test/nearest_pose_search_unit_tb.sv =====
`timescale 1ns / 100ps
// nearest_pose_search_unit_tb: stimulus, pacing and verdict for the nearest pose search unit
// depends on nps_pkg, nearest_pose_search_unit and nps_result_checker
module nearest_pose_search_unit_tb;

    localparam int CLK_HALF     = 6;
    localparam int SHORT_POSES  = 140;
    localparam int LONG_POSES   = nps_pkg::MAX_POSES + 6;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int BEGIN_PAD_W  = nps_pkg::CFG_DATA_W - nps_pkg::IDX_W;

    // index with no register behind it
    localparam logic [nps_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [nps_pkg::POSE_W-1:0] COORD_MAX = 24'h7FFFFF;
    localparam logic [nps_pkg::POSE_W-1:0] COORD_MIN = 24'h800000;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic [nps_pkg::CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [nps_pkg::CFG_DATA_W-1:0]    i_cfg_data    = '0;
    logic                              i_pose_valid  = 1'b0;
    logic signed [nps_pkg::POSE_W-1:0] i_pose_x      = '0;
    logic signed [nps_pkg::POSE_W-1:0] i_pose_y      = '0;
    logic                              i_last_pose   = 1'b0;
    logic                              i_res_ready   = 1'b0;
    logic                              o_pose_ready;
    logic                              o_res_valid;
    logic                              o_found;
    logic [nps_pkg::IDX_W-1:0]         o_nearest_index;
    logic [nps_pkg::ROOT_W-1:0]        o_nearest_distance;

    int err_count;
    int pending;
    int res_count;

    int send_idle_pct = 30;
    int recv_idle_pct = 81;
    bit hold_start    = 1'b0;
    int hold_left     = 0;
    int cycle_count   = 0;

    int poses_sent    = 0;
    int trajectories  = 0;
    int settings      = 0;
    logic [nps_pkg::POSE_W-1:0] cur_ref_x = '0;
    logic [nps_pkg::POSE_W-1:0] cur_ref_y = '0;

    nearest_pose_search_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_pose_valid       (i_pose_valid),
        .o_pose_ready       (o_pose_ready),
        .i_pose_x           (i_pose_x),
        .i_pose_y           (i_pose_y),
        .i_last_pose        (i_last_pose),
        .o_res_valid        (o_res_valid),
        .i_res_ready        (i_res_ready),
        .o_found            (o_found),
        .o_nearest_index    (o_nearest_index),
        .o_nearest_distance (o_nearest_distance)
    );

    nps_result_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_pose_valid       (i_pose_valid),
        .i_pose_ready       (o_pose_ready),
        .i_pose_x           (i_pose_x),
        .i_pose_y           (i_pose_y),
        .i_last_pose        (i_last_pose),
        .i_res_valid        (o_res_valid),
        .i_res_ready        (i_res_ready),
        .i_found            (o_found),
        .i_nearest_index    (o_nearest_index),
        .i_nearest_distance (o_nearest_distance),
        .o_err_count        (err_count),
        .o_pending          (pending),
        .o_res_count        (res_count)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left   = hold_left - 1;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one pose request, with a random gap first
    task automatic offer_pose(input logic [nps_pkg::POSE_W-1:0] x,
                              input logic [nps_pkg::POSE_W-1:0] y,
                              input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_pose_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_pose_valid <= 1'b1;
        i_pose_x     <= x;
        i_pose_y     <= y;
        i_last_pose  <= last;
        do @(posedge i_clk); while (!o_pose_ready);
        poses_sent = poses_sent + 1;
    endtask

    // stop offering and wait until every result has been taken
    task automatic drain();
        i_pose_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all registers, optionally poking the unused index as well
    task automatic program_regs(input logic [nps_pkg::CFG_DATA_W-1:0] rx,
                                input logic [nps_pkg::CFG_DATA_W-1:0] ry,
                                input logic [nps_pkg::CFG_DATA_W-1:0] begin_word,
                                input bit spare);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= nps_pkg::CFG_REF_X;
        i_cfg_data  <= rx;
        @(posedge i_clk);
        i_cfg_index <= nps_pkg::CFG_REF_Y;
        i_cfg_data  <= ry;
        @(posedge i_clk);
        if (spare) begin
            i_cfg_index <= CFG_SPARE;
            i_cfg_data  <= nps_pkg::CFG_DATA_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_index <= nps_pkg::CFG_BEGIN_INDEX;
        i_cfg_data  <= begin_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_ref_x   = rx;
        cur_ref_y   = ry;
        settings    = settings + 1;
    endtask

    // coordinate: extremes, random, or on or next to the reference point
    function automatic logic [nps_pkg::POSE_W-1:0] pick_coord(
        input logic [nps_pkg::POSE_W-1:0] centre
    );
        case ($urandom_range(9))
            0, 1, 2, 3: return centre + nps_pkg::POSE_W'($urandom_range(8))
                               - nps_pkg::POSE_W'(4);
            4:          return centre;
            5:          return COORD_MAX;
            6:          return COORD_MIN;
            default:    return nps_pkg::POSE_W'($urandom);
        endcase
    endfunction

    // begin index mostly zero or small, sometimes late, upper bits random
    function automatic logic [nps_pkg::CFG_DATA_W-1:0] pick_begin();
        logic [nps_pkg::IDX_W-1:0] first;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: first = '0;
            5, 6:          first = nps_pkg::IDX_W'($urandom_range(1, 6));
            7:             first = '1;
            default:       first = nps_pkg::IDX_W'($urandom);
        endcase
        return {BEGIN_PAD_W'($urandom), first};
    endfunction

    task automatic random_setting();
        program_regs(pick_coord(nps_pkg::POSE_W'(0)), pick_coord(nps_pkg::POSE_W'(0)),
                     pick_begin(), $urandom_range(3) == 0);
    endtask

    task automatic run_trajectory(input int len);
        for (int n = 0; n < len; n++) begin
            offer_pose(pick_coord(cur_ref_x), pick_coord(cur_ref_y), n == len - 1);
        end
        trajectories = trajectories + 1;
    endtask

    function automatic int pick_length();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(13, 40);
        end
        return $urandom_range(1, 12);
    endfunction

    // stimulus and verdict
    initial begin
        int phase_start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: exact hit after a miss
        offer_pose(nps_pkg::POSE_W'(3), nps_pkg::POSE_W'(4), 1'b0);
        offer_pose(nps_pkg::POSE_W'(0), nps_pkg::POSE_W'(0), 1'b1);
        trajectories = trajectories + 1;

        // farthest corner, then a tie where the earliest pose must win
        drain();
        program_regs(COORD_MIN, COORD_MIN, '0, 1'b1);
        offer_pose(COORD_MAX, COORD_MAX, 1'b1);
        offer_pose(COORD_MIN + nps_pkg::POSE_W'(3), COORD_MIN + nps_pkg::POSE_W'(4), 1'b0);
        offer_pose(COORD_MIN + nps_pkg::POSE_W'(4), COORD_MIN + nps_pkg::POSE_W'(3), 1'b0);
        offer_pose(COORD_MIN + nps_pkg::POSE_W'(3), COORD_MIN + nps_pkg::POSE_W'(4), 1'b1);
        trajectories = trajectories + 2;

        // skipped exact hit below the begin index, junk in the upper data bits
        drain();
        program_regs(COORD_MAX, COORD_MIN, {14'h3FFF, 10'd2}, 1'b0);
        offer_pose(COORD_MAX, COORD_MIN, 1'b0);
        offer_pose(COORD_MAX - nps_pkg::POSE_W'(7), COORD_MIN, 1'b0);
        offer_pose(COORD_MAX, COORD_MIN + nps_pkg::POSE_W'(2), 1'b0);
        offer_pose(COORD_MAX - nps_pkg::POSE_W'(1), COORD_MIN + nps_pkg::POSE_W'(1), 1'b1);
        trajectories = trajectories + 1;

        // nothing searched: begin index at its top, then past a short trajectory
        drain();
        program_regs('0, '0, nps_pkg::CFG_DATA_W'(1023), 1'b0);
        offer_pose(nps_pkg::POSE_W'(1), nps_pkg::POSE_W'(1), 1'b0);
        offer_pose(nps_pkg::POSE_W'(2), nps_pkg::POSE_W'(2), 1'b0);
        offer_pose(nps_pkg::POSE_W'(0), nps_pkg::POSE_W'(0), 1'b1);
        drain();
        program_regs('0, '0, nps_pkg::CFG_DATA_W'(3), 1'b1);
        offer_pose(nps_pkg::POSE_W'(5), nps_pkg::POSE_W'(5), 1'b1);
        trajectories = trajectories + 2;

        // random trajectories under three pacing schemes
        for (int phase = 0; phase < 3; phase++) begin
            drain();
            case (phase)
                0: begin send_idle_pct = 30; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            random_setting();
            phase_start = poses_sent;
            while (poses_sent - phase_start < SHORT_POSES) begin
                run_trajectory(pick_length());
                if ($urandom_range(3) == 0) begin
                    drain();
                    random_setting();
                end
            end
        end

        // long hold-off on results while poses keep coming, so the input stalls
        drain();
        hold_start = 1'b1;
        for (int n = 0; n < 6; n++) begin
            run_trajectory(4);
        end

        // over-long trajectory: best near the end of range, exact hit past the limit
        drain();
        program_regs(pick_coord(nps_pkg::POSE_W'(0)), pick_coord(nps_pkg::POSE_W'(0)),
                     nps_pkg::CFG_DATA_W'(1000), 1'b0);
        for (int n = 0; n < LONG_POSES; n++) begin
            if (n == nps_pkg::MAX_POSES - 1) begin
                offer_pose(cur_ref_x + nps_pkg::POSE_W'(1), cur_ref_y, 1'b0);
            end else if (n == LONG_POSES - 1) begin
                offer_pose(cur_ref_x, cur_ref_y, 1'b1);
            end else begin
                offer_pose(nps_pkg::POSE_W'($urandom), nps_pkg::POSE_W'($urandom), 1'b0);
            end
        end
        trajectories = trajectories + 1;

        drain();
        $display("covered %0d poses in %0d trajectories under %0d register settings",
                 poses_sent, trajectories, settings);
        $display("%0d results checked, %0d mismatches", res_count, err_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
